// File: hdl/gedge_pkg.sv
`timescale 1ns / 1ps
// Package for the graph edge table: sizes, operation and register codes,
// stream item layouts and the structs passed between the submodules.
// No dependencies.
package gedge_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int MAX_EDGES    = 1024;

    localparam int VID_W   = 9;                    // vertex id, 0..MAX_VERTICES
    localparam int ECNT_W  = 11;                   // edge id or count, 0..MAX_EDGES
    localparam int EADDR_W = $clog2(MAX_EDGES);    // slot address
    localparam int DEG_W   = 12;
    localparam int KIND_W  = 3;
    localparam int DIR_W   = 2;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [KIND_W-1:0] KIND_ADD_VERTEX = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD_EDGE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIND       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NEXT       = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DEGREE     = 3'd4;

    localparam logic [DIR_W-1:0] DIR_ANY = 2'd0;
    localparam logic [DIR_W-1:0] DIR_IN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_OUT = 2'd2;
    localparam logic [DIR_W-1:0] DIR_ALT = 2'd3;   // behaves as any

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_LIMIT   = 1'd1;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 64;

    // input tdata, lowest field last
    typedef struct packed {
        logic [DIR_W-1:0]  direction;
        logic              undirected;
        logic [ECNT_W-1:0] edge_id;
        logic [VID_W-1:0]  vert_b;
        logic [VID_W-1:0]  vert_a;
    } in_item_t;

    // output tdata, lowest field last
    typedef struct packed {
        logic [1:0]        pad;
        logic [ECNT_W-1:0] edge_count;
        logic [VID_W-1:0]  vertex_count;
        logic [VID_W-1:0]  target_vertex;
        logic [VID_W-1:0]  source_vertex;
        logic [DEG_W-1:0]  degree;
        logic              found;
        logic [ECNT_W-1:0] result_id;
    } out_item_t;

    typedef struct packed {
        logic [VID_W-1:0] src;
        logic [VID_W-1:0] tgt;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef struct packed {
        logic [VID_W-1:0] va;
        logic [VID_W-1:0] vb;
    } query_t;

    typedef struct packed {
        logic fwd;      // source is va and target is vb
        logic rev;      // source is vb and target is va
        logic at_src;   // source is va
        logic at_tgt;   // target is va
    } cmp_res_t;

endpackage

// File: hdl/gedge_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module gedge_ram #(
    parameter int DATA_W = 18,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/gedge_cmp.sv
`timescale 1ns / 1ps
// Shared slot compare unit: matches one stored edge against the query vertices.
// Depends on gedge_pkg.
module gedge_cmp (
    input  gedge_pkg::slot_t    slot,
    input  gedge_pkg::query_t   query,
    output gedge_pkg::cmp_res_t res
);
    import gedge_pkg::*;

    logic src_is_a, src_is_b, tgt_is_a, tgt_is_b;

    assign src_is_a = (slot.src == query.va);
    assign src_is_b = (slot.src == query.vb);
    assign tgt_is_a = (slot.tgt == query.va);
    assign tgt_is_b = (slot.tgt == query.vb);

    assign res.fwd    = src_is_a & tgt_is_b;
    assign res.rev    = src_is_b & tgt_is_a;
    assign res.at_src = src_is_a;
    assign res.at_tgt = tgt_is_a;

endmodule

// File: hdl/gedge_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the graph edge table: takes an operation, walks the edge slots
// through the RAM and the compare unit, and holds the result register.
// Depends on gedge_pkg.
module gedge_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gedge_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic [gedge_pkg::KIND_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gedge_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic [gedge_pkg::VID_W-1:0]       vert_lim,
    input  logic [gedge_pkg::ECNT_W-1:0]      edge_lim,
    output logic                              ram_we,
    output logic [gedge_pkg::EADDR_W-1:0]     ram_waddr,
    output gedge_pkg::slot_t                  ram_wdata,
    output logic [gedge_pkg::EADDR_W-1:0]     ram_raddr,
    input  gedge_pkg::slot_t                  ram_rdata,
    output gedge_pkg::query_t                 cmp_query,
    input  gedge_pkg::cmp_res_t               cmp_res
);
    import gedge_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_FIN
    } state_t;

    state_t              state_reg;
    logic                m_tvalid_reg;
    out_item_t           m_tdata_reg;
    logic [VID_W-1:0]    vused_reg;
    logic [ECNT_W-1:0]   eused_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [VID_W-1:0]    va_reg;
    logic [VID_W-1:0]    vb_reg;
    logic                und_reg;
    logic [DIR_W-1:0]    dir_reg;
    logic [ECNT_W-1:0]   issue_reg;
    logic [ECNT_W-1:0]   end_reg;
    logic                pend_reg;
    logic [EADDR_W-1:0]  pend_idx_reg;
    logic [ECNT_W-1:0]   rid_reg;
    logic                fnd_reg;
    logic [DEG_W-1:0]    deg_reg;
    logic [VID_W-1:0]    src_reg;
    logic [VID_W-1:0]    tgt_reg;

    in_item_t            in_item;
    logic                accept;
    logic                add_ok;
    logic                deg_ok;
    logic [ECNT_W-1:0]   scan_end;
    logic [ECNT_W-1:0]   eid_m1;
    logic                hit;

    assign in_item  = in_item_t'(s_tdata);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign add_ok   = (in_item.vert_a != '0) && (in_item.vert_b != '0) && (eused_reg < edge_lim);
    assign deg_ok   = (in_item.vert_a != '0) && (in_item.vert_a <= vused_reg)
                      && (in_item.vert_a <= vert_lim);
    // only the first edges_used slots are occupied, so stop there, or at the edge limit if lower
    assign scan_end = (edge_lim < eused_reg) ? edge_lim : eused_reg;
    assign eid_m1   = in_item.edge_id - ECNT_W'(1);

    assign ram_we        = accept && (s_tuser == KIND_ADD_EDGE) && add_ok;
    assign ram_waddr     = eused_reg[EADDR_W-1:0];
    assign ram_wdata.src = in_item.vert_a;
    assign ram_wdata.tgt = in_item.vert_b;
    assign ram_raddr     = (state_reg == ST_IDLE) ? eid_m1[EADDR_W-1:0]
                                                  : issue_reg[EADDR_W-1:0];

    assign cmp_query.va = va_reg;
    assign cmp_query.vb = vb_reg;

    always_comb begin
        if (kind_reg == KIND_FIND) begin
            hit = cmp_res.fwd | (und_reg & cmp_res.rev);
        end else begin
            unique case (dir_reg)
                DIR_IN:  hit = cmp_res.at_tgt;
                DIR_OUT: hit = cmp_res.at_src;
                default: hit = cmp_res.at_src | cmp_res.at_tgt;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            vused_reg    <= '0;
            eused_reg    <= '0;
            pend_reg     <= 1'b0;
            issue_reg    <= '0;
            rid_reg      <= '0;
            fnd_reg      <= 1'b0;
            deg_reg      <= '0;
            src_reg      <= '0;
            tgt_reg      <= '0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_FIN) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg  <= s_tuser;
                        va_reg    <= in_item.vert_a;
                        vb_reg    <= in_item.vert_b;
                        und_reg   <= in_item.undirected;
                        dir_reg   <= (in_item.direction == DIR_ALT) ? DIR_ANY
                                                                    : in_item.direction;
                        pend_reg  <= 1'b0;
                        end_reg   <= scan_end;
                        unique case (s_tuser)
                            KIND_ADD_VERTEX: begin
                                if (vused_reg < vert_lim) begin
                                    vused_reg <= vused_reg + VID_W'(1);
                                    rid_reg   <= ECNT_W'(vused_reg) + ECNT_W'(1);
                                    fnd_reg   <= 1'b1;
                                end
                                state_reg <= ST_FIN;
                            end
                            KIND_ADD_EDGE: begin
                                if (add_ok) begin
                                    eused_reg <= eused_reg + ECNT_W'(1);
                                    rid_reg   <= eused_reg + ECNT_W'(1);
                                    fnd_reg   <= 1'b1;
                                    src_reg   <= in_item.vert_a;
                                    tgt_reg   <= in_item.vert_b;
                                end
                                state_reg <= ST_FIN;
                            end
                            KIND_FIND: begin
                                state_reg <= ST_SCAN;
                            end
                            KIND_NEXT: begin
                                if (in_item.edge_id == '0) begin
                                    state_reg <= ST_SCAN;
                                end else if (in_item.edge_id <= edge_lim
                                             && in_item.edge_id <= eused_reg) begin
                                    // start edge is being read; check it touches va
                                    issue_reg <= in_item.edge_id;
                                    state_reg <= ST_CHECK;
                                end else begin
                                    state_reg <= ST_FIN;
                                end
                            end
                            KIND_DEGREE: begin
                                if (deg_ok) begin
                                    fnd_reg   <= 1'b1;
                                    state_reg <= ST_SCAN;
                                end else begin
                                    state_reg <= ST_FIN;
                                end
                            end
                            default: state_reg <= ST_FIN;
                        endcase
                    end
                end
                ST_CHECK: begin
                    state_reg <= (cmp_res.at_src | cmp_res.at_tgt) ? ST_SCAN : ST_FIN;
                end
                ST_SCAN: begin
                    if (pend_reg && hit && kind_reg != KIND_DEGREE) begin
                        rid_reg   <= ECNT_W'(pend_idx_reg) + ECNT_W'(1);
                        fnd_reg   <= 1'b1;
                        src_reg   <= ram_rdata.src;
                        tgt_reg   <= ram_rdata.tgt;
                        state_reg <= ST_FIN;
                    end else begin
                        if (pend_reg && kind_reg == KIND_DEGREE) begin
                            deg_reg <= deg_reg + DEG_W'(cmp_res.at_src)
                                               + DEG_W'(cmp_res.at_tgt);
                        end
                        if (issue_reg < end_reg) begin
                            pend_reg     <= 1'b1;
                            pend_idx_reg <= issue_reg[EADDR_W-1:0];
                            issue_reg    <= issue_reg + ECNT_W'(1);
                        end else begin
                            // drain the last read, then finish
                            pend_reg <= 1'b0;
                            if (!pend_reg) begin
                                state_reg <= ST_FIN;
                            end
                        end
                    end
                end
                ST_FIN: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg.pad           <= '0;
                        m_tdata_reg.edge_count    <= eused_reg;
                        m_tdata_reg.vertex_count  <= vused_reg;
                        m_tdata_reg.target_vertex <= tgt_reg;
                        m_tdata_reg.source_vertex <= src_reg;
                        m_tdata_reg.degree        <= deg_reg;
                        m_tdata_reg.found         <= fnd_reg;
                        m_tdata_reg.result_id     <= rid_reg;
                        m_tvalid_reg              <= 1'b1;
                        // clear the working result for the next operation
                        rid_reg                   <= '0;
                        fnd_reg                   <= 1'b0;
                        deg_reg                   <= '0;
                        src_reg                   <= '0;
                        tgt_reg                   <= '0;
                        issue_reg                 <= '0;
                        state_reg                 <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/graph_edge_table_top.sv
`timescale 1ns / 1ps
// Top level of the graph edge table: limit registers, edge slot RAM, compare
// unit and sequencer. Depends on gedge_pkg, gedge_ram, gedge_cmp, gedge_ctrl.

// Directed edge table with vertex allocation, one operation per input transfer
// and one result transfer for each. Edges fill slots from the lowest upwards and
// are never removed, so the occupied slots are always the first edge_count ones
// and the slot RAM needs no clearing after reset. Add vertex and add edge go from
// the transfer straight to the finish state, which loads the result register
// once the output register is free and then makes the input ready again. Find,
// next incident and degree walk the occupied slots within the edge limit through
// the single read port of the slot RAM, one slot per cycle, up to 1024 slots;
// next incident from a given edge first checks that edge in a check state. Find
// and next incident stop at the first match. The input is not ready while an
// operation runs; a finished result waits in the output register, and the next
// result is held until that one has been taken.
module graph_edge_table_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // vert_a[8:0], vert_b[17:9], edge_id[28:18], undirected[29], direction[31:30]
    input  logic [gedge_pkg::IN_DATA_W-1:0]   s_tdata,
    // kind[2:0]
    input  logic [gedge_pkg::KIND_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // result_id[10:0], found[11], degree[23:12], source_vertex[32:24],
    // target_vertex[41:33], vertex_count[50:42], edge_count[61:51], zero[63:62]
    output logic [gedge_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                              cfg_we,
    input  logic [gedge_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gedge_pkg::CFG_W-1:0]       cfg_data
);
    import gedge_pkg::*;

    logic [VID_W-1:0]   vlimit_reg;
    logic [ECNT_W-1:0]  elimit_reg;
    logic [VID_W-1:0]   vert_lim;
    logic [ECNT_W-1:0]  edge_lim;

    logic               ram_we;
    logic [EADDR_W-1:0] ram_waddr;
    logic [EADDR_W-1:0] ram_raddr;
    slot_t              ram_wdata;
    slot_t              ram_rdata;
    query_t             cmp_query;
    cmp_res_t           cmp_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vlimit_reg <= VID_W'(MAX_VERTICES);
            elimit_reg <= ECNT_W'(MAX_EDGES);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_VERTEX_LIMIT: vlimit_reg <= cfg_data[VID_W-1:0];
                CFG_EDGE_LIMIT:   elimit_reg <= cfg_data[ECNT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp the limits to the table sizes
    assign vert_lim = (vlimit_reg > VID_W'(MAX_VERTICES)) ? VID_W'(MAX_VERTICES) : vlimit_reg;
    assign edge_lim = (elimit_reg > ECNT_W'(MAX_EDGES)) ? ECNT_W'(MAX_EDGES) : elimit_reg;

    gedge_ram #(
        .DATA_W (SLOT_W),
        .ADDR_W (EADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gedge_cmp u_cmp (
        .slot  (ram_rdata),
        .query (cmp_query),
        .res   (cmp_res)
    );

    gedge_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .vert_lim  (vert_lim),
        .edge_lim  (edge_lim),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .cmp_query (cmp_query),
        .cmp_res   (cmp_res)
    );

`ifndef SYNTHESIS
    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready straight after a transfer");

    a_no_id_without_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[11] |-> m_tdata[10:0] == 11'd0)
        else $error("result id given without found");

    a_no_degree_without_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[23:12] != 12'd0 |-> m_tdata[11])
        else $error("degree given without found");

    a_edge_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[61:51] <= 11'(MAX_EDGES))
        else $error("edge count beyond table size");
`endif

endmodule
